// File: rtl/core/atp_pkg.sv
// atp_pkg: types, constants and the arctangent table shared by the
// accelerometer pitch low-pass block. No dependencies.
`default_nettype none

package atp_pkg;

  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned ROOT_STEPS    = 24;
  localparam int unsigned ATAN_LEN      = 24;
  localparam int unsigned WEIGHT_W      = 17;
  localparam int          PITCH_LIMIT   = 23040;
  localparam logic [16:0] WEIGHT_ONE    = 17'd65536;
  localparam logic [16:0] WEIGHT_RESET  = 17'd26214;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               mag_zero;
  } atp_item_t;

  typedef struct packed {
    logic signed [15:0] pitch_now;
    logic signed [15:0] pitch_smoothed;
  } atp_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_ROOT,
    ST_ROT,
    ST_ROUND,
    ST_FILT_A,
    ST_FILT_B,
    ST_DONE
  } atp_state_e;

  // atan(2^-i) in degrees, Q16.16
  function automatic logic [21:0] atan_deg(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/atp_front.sv
// atp_front: input queue that takes accelerometer beats and flags a zero
// y/z magnitude. Depends on atp_pkg.
`default_nettype none

module atp_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  output logic               full_o,
  input  wire signed [15:0]  accel_x_i,
  input  wire signed [15:0]  accel_y_i,
  input  wire signed [15:0]  accel_z_i,
  output logic               item_valid_o,
  output atp_pkg::atp_item_t item_o,
  input  wire                item_take_i
);
  import atp_pkg::*;

  atp_item_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]     count_q;
  logic                    wr_en, rd_en;
  atp_item_t               new_item;

  assign full_o       = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign wr_en        = push_i && !full_o;
  assign rd_en        = item_take_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    new_item.accel_x  = accel_x_i;
    new_item.accel_y  = accel_y_i;
    new_item.accel_z  = accel_z_i;
    new_item.mag_zero = (accel_y_i == '0) && (accel_z_i == '0);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/atp_back.sv
// atp_back: sequencer with square root and CORDIC vectoring sharing one iteration
// counter, followed by a low-pass filter. Depends on atp_pkg.
`default_nettype none

module atp_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                item_valid_i,
  input  atp_pkg::atp_item_t item_i,
  output logic               item_take_o,
  input  wire [16:0]         weight_i,
  output logic               res_valid_o,
  output atp_pkg::atp_res_t  res_o,
  input  wire                res_ready_i
);
  import atp_pkg::*;

  localparam int unsigned NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [4:0]  ROT_LAST  = 5'(NSTEPS - 1);
  localparam logic [4:0]  ROOT_LAST = 5'(ROOT_STEPS - 1);

  atp_state_e          state_q, state_d;
  logic [4:0]          it_q;
  logic signed [15:0]  x_q, y_q, z_q;
  logic [31:0]         sq_q;
  logic [47:0]         n_q;
  logic [27:0]         rem_q;
  logic [23:0]         root_q;
  logic signed [27:0]  cx_q, cy_q;
  logic signed [31:0]  ang_q;
  logic signed [15:0]  pitch_q, smoothed_q;
  logic signed [33:0]  prod_q;

  logic signed [15:0]  sq_op;
  logic signed [31:0]  sq_prod;
  logic [27:0]         rem_sh, trial, rem_d;
  logic [23:0]         root_d;
  logic signed [27:0]  dx, dy, xs;
  logic signed [31:0]  atan_v, rnd;
  logic [16:0]         w_eff, w_inv;
  logic signed [34:0]  mul_b, acc;
  logic signed [15:0]  zero_pitch, sat_pitch;

  // next state and handshakes
  always_comb begin
    state_d     = state_q;
    item_take_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          state_d     = item_i.mag_zero ? ST_FILT_A : ST_SQ_Y;
        end
      end
      ST_SQ_Y:   state_d = ST_SQ_Z;
      ST_SQ_Z:   state_d = ST_ROOT;
      ST_ROOT: begin
        if (it_q == ROOT_LAST) state_d = ST_ROT;
      end
      ST_ROT: begin
        if (it_q == ROT_LAST) state_d = ST_ROUND;
      end
      ST_ROUND:  state_d = ST_FILT_A;
      ST_FILT_A: state_d = ST_FILT_B;
      ST_FILT_B: state_d = ST_DONE;
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath arithmetic
  always_comb begin
    sq_op   = (state_q == ST_SQ_Y) ? y_q : z_q;
    sq_prod = sq_op * sq_op;

    rem_sh = {rem_q[25:0], n_q[47:46]};
    trial  = {2'b00, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[22:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[22:0], 1'b0};
    end

    xs     = 28'(x_q);
    dx     = cy_q >>> it_q;
    dy     = cx_q >>> it_q;
    atan_v = $signed({10'b0, atan_deg(it_q)});

    rnd = (ang_q + 32'sd128) >>> 8;
    if (rnd > PITCH_LIMIT) begin
      sat_pitch = 16'(PITCH_LIMIT);
    end else if (rnd < -PITCH_LIMIT) begin
      sat_pitch = 16'(-PITCH_LIMIT);
    end else begin
      sat_pitch = rnd[15:0];
    end

    if ($signed(item_i.accel_x) < 0) begin
      zero_pitch = 16'(PITCH_LIMIT);
    end else if ($signed(item_i.accel_x) > 0) begin
      zero_pitch = 16'(-PITCH_LIMIT);
    end else begin
      zero_pitch = '0;
    end

    w_eff = (weight_i > WEIGHT_ONE) ? WEIGHT_ONE : weight_i;
    w_inv = WEIGHT_ONE - w_eff;
    mul_b = $signed({1'b0, w_inv}) * smoothed_q;
    acc   = {prod_q[33], prod_q} + mul_b;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          x_q     <= item_i.accel_x;
          y_q     <= item_i.accel_y;
          z_q     <= item_i.accel_z;
          pitch_q <= zero_pitch;
        end
      end
      ST_SQ_Y: begin
        sq_q <= sq_prod;
      end
      ST_SQ_Z: begin
        n_q    <= {sq_q + sq_prod, 16'b0};
        rem_q  <= '0;
        root_q <= '0;
        cy_q   <= -(xs <<< 8);
        ang_q  <= '0;
      end
      ST_ROOT: begin
        rem_q  <= rem_d;
        root_q <= root_d;
        n_q    <= {n_q[45:0], 2'b00};
        if (it_q == ROOT_LAST) cx_q <= $signed({4'b0, root_d});
      end
      ST_ROT: begin
        if (!cy_q[27]) begin
          cx_q  <= cx_q + dx;
          cy_q  <= cy_q - dy;
          ang_q <= ang_q + atan_v;
        end else begin
          cx_q  <= cx_q - dx;
          cy_q  <= cy_q + dy;
          ang_q <= ang_q - atan_v;
        end
      end
      ST_ROUND: begin
        pitch_q <= sat_pitch;
      end
      ST_FILT_A: begin
        prod_q <= $signed({1'b0, w_eff}) * pitch_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      it_q       <= '0;
      smoothed_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_ROOT: it_q <= (it_q == ROOT_LAST) ? '0 : it_q + 1'b1;
        ST_ROT:  it_q <= it_q + 1'b1;
        default: it_q <= '0;
      endcase
      if (state_q == ST_FILT_B) smoothed_q <= acc[31:16];
    end
  end

  assign res_o.pitch_now      = pitch_q;
  assign res_o.pitch_smoothed = smoothed_q;

endmodule

`default_nettype wire

// File: rtl/core/accel_tilt_pitch_lowpass.sv
// accel_tilt_pitch_lowpass: top level with weight register and result register.
// Instantiates atp_front and atp_back; depends on atp_pkg.
`default_nettype none

// Pitch from a raw accelerometer triple, atan2(-x, sqrt(y*y+z*z)) in Q8.8
// degrees, with a first-order low-pass whose new-sample weight is written as a
// Q0.16 value on cfg_wdata_i (reset 0.4, values above 1.0 act as 1.0). In the
// back end each beat goes through the 24-step square root and CORDIC passes,
// which share one iteration counter; a beat with y and z both zero skips both.
// A two-entry input queue and a result register let pushes and pops go on while
// the back end is busy. Write the weight only while no beat is in flight.
module accel_tilt_pitch_lowpass #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push,
  output logic              full,
  input  wire signed [15:0] accel_x_i,
  input  wire signed [15:0] accel_y_i,
  input  wire signed [15:0] accel_z_i,
  output logic              empty,
  input  wire               pop,
  output logic signed [15:0] pitch_now_o,
  output logic signed [15:0] pitch_smoothed_o,
  input  wire               cfg_we_i,
  input  wire [16:0]        cfg_wdata_i
);
  import atp_pkg::*;

  atp_item_t   item;
  logic        item_valid, item_take;
  atp_res_t    res, out_q;
  logic        res_valid, res_ready;
  logic        out_valid_q;
  logic [16:0] weight_q;

  atp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  atp_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .weight_i     (weight_q),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  assign res_ready = !out_valid_q || pop;

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      weight_q    <= WEIGHT_RESET;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) weight_q <= cfg_wdata_i;
    end
  end

  assign empty            = !out_valid_q;
  assign pitch_now_o      = out_q.pitch_now;
  assign pitch_smoothed_o = out_q.pitch_smoothed;

endmodule

`default_nettype wire

// File: rtl/core/atp_checker.sv
// atp_checker: port-level assertions for accel_tilt_pitch_lowpass, with the
// bind that attaches it. Depends only on the top level's ports.
`default_nettype none

module atp_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               push,
  input wire               full,
  input wire signed [15:0] accel_x_i,
  input wire signed [15:0] accel_y_i,
  input wire signed [15:0] accel_z_i,
  input wire               empty,
  input wire               pop,
  input wire signed [15:0] pitch_now_o,
  input wire signed [15:0] pitch_smoothed_o,
  input wire               cfg_we_i,
  input wire [16:0]        cfg_wdata_i
);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty under reset");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pitch_now_o) && $stable(pitch_smoothed_o)))
    else $error("waiting result changed before pop");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pitch_now_o <= 16'sd23040 && pitch_now_o >= -16'sd23040))
    else $error("pitch_now_o out of range");

  a_smooth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pitch_smoothed_o <= 16'sd23040 && pitch_smoothed_o >= -16'sd23040))
    else $error("pitch_smoothed_o out of range");

endmodule

bind accel_tilt_pitch_lowpass atp_checker u_atp_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for accel_tilt_pitch_lowpass, driven through its queue and
// weight ports, with a bit-accurate pitch and low-pass predictor kept in step with every
// accepted beat. Depends on atp_pkg and the block under test.
module tb_top;
  import atp_pkg::*;

  localparam int unsigned CORDIC_STEPS   = 16;
  localparam int unsigned ROT_STEPS      = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int unsigned SETTLE_CYCLES  = 64;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic              clk_i       = 1'b0;
  logic              rst_ni;
  logic              push        = 1'b0;
  logic              full;
  logic signed [15:0] accel_x_i  = '0;
  logic signed [15:0] accel_y_i  = '0;
  logic signed [15:0] accel_z_i  = '0;
  logic              empty;
  logic              pop         = 1'b0;
  logic signed [15:0] pitch_now_o;
  logic signed [15:0] pitch_smoothed_o;
  logic              cfg_we_i    = 1'b0;
  logic [16:0]       cfg_wdata_i = '0;

  // atan(2^-i) in degrees, q16.16
  longint arctan_step_q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  atp_res_t           pitch_expected [$];
  logic [16:0]        weight_shadow  = WEIGHT_RESET;
  logic signed [15:0] smooth_state   = '0;
  logic signed [15:0] predicted_now;
  atp_res_t           predicted;
  atp_res_t           wanted;
  int unsigned        mismatch_count = 0;
  int unsigned        stall_cycles   = 0;
  bit                 tx_calm        = 1'b0;
  bit                 rx_calm        = 1'b0;
  bit                 rx_hold_req    = 1'b0;
  int unsigned        hold_cnt;

  accel_tilt_pitch_lowpass #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .empty           (empty),
    .pop             (pop),
    .pitch_now_o     (pitch_now_o),
    .pitch_smoothed_o(pitch_smoothed_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned probe;
    res   = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n   = n - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] tilt_pitch_q8(input logic signed [15:0] x,
                                                       input logic signed [15:0] y,
                                                       input logic signed [15:0] z);
    longint          sx, sy, sz, cx, cy, dx, dy, ang, q;
    longint unsigned sq, mag;
    sx  = x;
    sy  = y;
    sz  = z;
    sq  = sy * sy + sz * sz;
    mag = root_floor(sq << 16);
    if (mag == 0) begin
      if (sx < 0) return 16'(PITCH_LIMIT);
      if (sx > 0) return 16'(-PITCH_LIMIT);
      return '0;
    end
    cx  = longint'(mag);
    cy  = -sx * 256;
    ang = 0;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        ang = ang + arctan_step_q16[i];
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        ang = ang - arctan_step_q16[i];
      end
    end
    q = (ang + 128) >>> 8;
    if (q > PITCH_LIMIT) q = PITCH_LIMIT;
    if (q < -PITCH_LIMIT) q = -PITCH_LIMIT;
    return 16'(q);
  endfunction

  function automatic logic signed [15:0] lowpass_next(input logic signed [15:0] p,
                                                      input logic signed [15:0] prev,
                                                      input logic [16:0] wt);
    longint w, pl, ol, acc;
    w   = (wt > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(wt);
    pl  = p;
    ol  = prev;
    acc = w * pl + (65536 - w) * ol;
    return 16'(acc >>> 16);
  endfunction

  task automatic report_mismatch(input string what, input logic signed [15:0] got,
                                 input logic signed [15:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatch_count++;
  endtask

  // predict on every accepted beat
  always @(posedge clk_i) begin
    if (rst_ni && push && full === 1'b0) begin
      predicted_now            = tilt_pitch_q8(accel_x_i, accel_y_i, accel_z_i);
      smooth_state             = lowpass_next(predicted_now, smooth_state, weight_shadow);
      predicted.pitch_now      = predicted_now;
      predicted.pitch_smoothed = smooth_state;
      pitch_expected.push_back(predicted);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && empty === 1'b0) begin
      if (pitch_expected.size() == 0) begin
        report_mismatch("unexpected beat pitch_now", pitch_now_o, '0);
      end else begin
        wanted = pitch_expected.pop_front();
        if (pitch_now_o !== wanted.pitch_now)
          report_mismatch("pitch_now", pitch_now_o, wanted.pitch_now);
        if (pitch_smoothed_o !== wanted.pitch_smoothed)
          report_mismatch("pitch_smoothed", pitch_smoothed_o, wanted.pitch_smoothed);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && full === 1'b0) || (pop && empty === 1'b0)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side, with an occasional long hold-off
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        pop <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      pop <= rx_calm || ($urandom_range(99) >= 29);
    end
  end

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
    while (!tx_calm && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    accel_x_i <= x;
    accel_y_i <= y;
    accel_z_i <= z;
    do @(posedge clk_i); while (full !== 1'b0);
  endtask

  function automatic logic signed [15:0] near_zero();
    return 16'(int'($urandom_range(0, 64)) - 32);
  endfunction

  function automatic logic signed [15:0] pick_edge();
    case ($urandom_range(4))
      0:       return 16'sh8000;
      1:       return -16'sd1;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return 16'sh7fff;
    endcase
  endfunction

  task automatic send_random_sample();
    logic signed [15:0] x, y, z;
    int unsigned        kind;
    kind = $urandom_range(99);
    x    = 16'($urandom);
    y    = 16'($urandom);
    z    = 16'($urandom);
    if (kind < 15) begin
      x = near_zero();
      y = near_zero();
      z = near_zero();
    end else if (kind < 23) begin
      y = '0;
      z = '0;
      if ($urandom_range(3) == 0) x = near_zero();
    end else if (kind < 31) begin
      if ($urandom_range(1) == 1) y = '0;
      else z = '0;
    end else if (kind < 38) begin
      x = pick_edge();
      y = pick_edge();
      z = pick_edge();
    end else if (kind < 45) begin
      y = near_zero();
      z = near_zero();
    end
    send_sample(x, y, z);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (pitch_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_weight(input logic [16:0] w);
    cfg_wdata_i <= w;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    weight_shadow = w;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_edge_samples();
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd0, 16'sd0);
    send_sample(16'sh7fff, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sh7fff, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(16'sh7fff, -16'sd1, 16'sd0);
    send_sample(16'sh8000, 16'sd0, 16'sd1);
    send_sample(16'sd1, 16'sh7fff, 16'sh8000);
    send_sample(-16'sd1, 16'sh8000, 16'sh7fff);
    send_sample(16'sd16384, 16'sd0, 16'sd16384);
    send_sample(-16'sd16384, 16'sd16384, 16'sd0);
    drain_results();
  endtask

  task automatic test_weight_extremes();
    logic [16:0] extremes [5];
    extremes = '{17'd0, WEIGHT_ONE, 17'h1ffff, 17'd65537, 17'd1};
    foreach (extremes[k]) begin
      write_weight(extremes[k]);
      repeat ((k < 3) ? 150 : 100) send_random_sample();
      drain_results();
    end
  endtask

  task automatic test_random_weights();
    repeat (4) begin
      write_weight(17'($urandom_range(0, 65536)));
      repeat (250) send_random_sample();
      drain_results();
    end
  endtask

  task automatic test_no_idle();
    write_weight(WEIGHT_RESET);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (180) send_random_sample();
    drain_results();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // receiver holds off while beats keep coming, so the input side must stall
  task automatic test_input_stall();
    write_weight(17'($urandom_range(0, 131071)));
    rx_hold_req = 1'b1;
    repeat (24) send_random_sample();
    drain_results();
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edge_samples();
    test_weight_extremes();
    test_random_weights();
    test_no_idle();
    test_input_stall();
    drain_results();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/atp_pkg.sv
rtl/core/atp_front.sv
rtl/core/atp_back.sv
rtl/core/accel_tilt_pitch_lowpass.sv
rtl/core/atp_checker.sv
tb/tb_top.sv
